>>> hdl/dpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpq_pkg
// Widths, command and status codes and the job record that the front end
// passes to the back end.
// ----------------------------------------------------------------------------
package dpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 48;
  localparam int HANDLE_W    = 32;
  localparam int TMO_W       = 24;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;
  // unused code: no state change
  localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_DUE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // stamp: deadline for a push, current time for a pop
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   stamp;
  } job_t;

endpackage
`default_nettype wire

>>> hdl/dpq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpq_if
// Request and result channels of the deadline queue.
// ----------------------------------------------------------------------------
interface dpq_in_if;
  logic                        valid;
  logic                        ready;
  logic [dpq_pkg::CMD_W-1:0]    cmd;
  logic [dpq_pkg::HANDLE_W-1:0] handle;
  logic [dpq_pkg::TMO_W-1:0]    timeout_ms;
  modport source (output valid, cmd, handle, timeout_ms, input ready);
  modport sink (input valid, cmd, handle, timeout_ms, output ready);
endinterface

interface dpq_out_if;
  logic                        valid;
  logic                        ready;
  logic [dpq_pkg::HANDLE_W-1:0] out_handle;
  logic [dpq_pkg::STATUS_W-1:0] status;
  logic [dpq_pkg::COUNT_W-1:0]  entry_count;
  modport source (output valid, out_handle, status, entry_count, input ready);
  modport sink (input valid, out_handle, status, entry_count, output ready);
endinterface
`default_nettype wire

>>> hdl/dpq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpq_front
// Accepts requests, keeps the millisecond clock and turns each request into
// a job with its deadline or its time of pop already worked out.
// ----------------------------------------------------------------------------
module dpq_front (
  input  wire              clk,
  input  wire              rst_n,
  dpq_in_if.sink           in_ch,
  output dpq_pkg::job_t    job,
  output logic             job_valid,
  input  wire              job_ready
);
  import dpq_pkg::*;

  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W:0]   sum;
  logic              take;

  assign in_ch.ready = job_ready;
  assign job_valid   = in_ch.valid;
  assign take        = in_ch.valid & job_ready;
  assign sum         = {1'b0, now_r} + {{(TIME_W + 1 - TMO_W){1'b0}}, in_ch.timeout_ms};

  always_comb begin
    job.cmd    = in_ch.cmd;
    job.handle = in_ch.handle;
    if (in_ch.cmd == CMD_PUSH) begin
      job.stamp = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    end else begin
      job.stamp = now_r;
    end
  end

  always_comb begin
    now_nxt = now_r;
    if (take && in_ch.cmd == CMD_TICK && now_r != {TIME_W{1'b1}}) begin
      now_nxt = now_r + {{(TIME_W - 1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
    end else begin
      now_r <= now_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/dpq_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpq_fifo
// Two-entry job queue between front and back end.
// ----------------------------------------------------------------------------
module dpq_fifo (
  input  wire           clk,
  input  wire           rst_n,
  input  dpq_pkg::job_t wr_job,
  input  wire           wr_valid,
  output logic          wr_ready,
  output dpq_pkg::job_t rd_job,
  output logic          rd_valid,
  input  wire           rd_ready
);
  import dpq_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = mem_r[rp_r];
  assign wr       = wr_valid & wr_ready;
  assign rd       = rd_valid & rd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
  end

endmodule
`default_nettype wire

>>> hdl/dpq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpq_back
// Sorted row of cells holding (deadline, handle). Each cell decides locally
// whether to keep, take the new entry, or take a neighbor, so a push or pop
// updates the whole row at once. Results go to an output register.
// ----------------------------------------------------------------------------
module dpq_back (
  input  wire           clk,
  input  wire           rst_n,
  input  dpq_pkg::job_t job,
  input  wire           job_valid,
  output logic          job_ready,
  dpq_out_if.source     out_ch
);
  import dpq_pkg::*;

  logic [TIME_W-1:0]   dl_r [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] hd_r [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vld_r;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [QUEUE_DEPTH-1:0] later;
  logic                do_push, do_pop, go;
  logic [STATUS_W-1:0] st;
  logic [HANDLE_W-1:0] got;

  logic                out_valid_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [STATUS_W-1:0] status_r;
  logic [COUNT_W-1:0]  count_out_r;

  assign job_ready = !out_valid_r || out_ch.ready;
  assign go        = job_valid & job_ready;

  // empty cells count as later than anything
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      later[i] = !vld_r[i] || (job.stamp < dl_r[i]);
    end
  end

  always_comb begin
    do_push   = 1'b0;
    do_pop    = 1'b0;
    st        = ST_OK;
    got       = '0;
    count_nxt = count_r;
    case (job.cmd)
      CMD_PUSH: begin
        if (count_r == COUNT_W'(QUEUE_DEPTH)) begin
          st = ST_FULL;
        end else begin
          do_push   = 1'b1;
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      CMD_POP: begin
        if (!vld_r[0]) begin
          st = ST_EMPTY;
        end else if (dl_r[0] > job.stamp) begin
          st = ST_NOT_DUE;
        end else begin
          do_pop    = 1'b1;
          got       = hd_r[0];
          count_nxt = count_r - COUNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        count_r <= count_nxt;
        if (do_push) vld_r <= {vld_r[QUEUE_DEPTH-2:0], 1'b1};
        if (do_pop)  vld_r <= {1'b0, vld_r[QUEUE_DEPTH-1:1]};
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_handle_r <= got;
      status_r     <= st;
      count_out_r  <= count_nxt;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (do_push) begin
          if (later[i] && (i == 0 || !later[(i == 0) ? 0 : i - 1])) begin
            dl_r[i] <= job.stamp;
            hd_r[i] <= job.handle;
          end else if (i > 0 && later[(i == 0) ? 0 : i - 1]) begin
            dl_r[i] <= dl_r[(i == 0) ? 0 : i - 1];
            hd_r[i] <= hd_r[(i == 0) ? 0 : i - 1];
          end
        end else if (do_pop && i < QUEUE_DEPTH - 1) begin
          dl_r[i] <= dl_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          hd_r[i] <= hd_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_handle  = out_handle_r;
  assign out_ch.status      = status_r;
  assign out_ch.entry_count = count_out_r;

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_r) == int'(count_r))
    else $error("entry count out of step with cell valid bits");
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (vld_r[0] && dl_r[0] <= dl_r[1]))
    else $error("head cells out of order");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(status_r)))
    else $error("stalled result lost");

endmodule
`default_nettype wire

>>> hdl/deadline_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_priority_queue_unit
// Timer deadline queue: tick, push with timeout, pop earliest expired entry.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          cmd, handle, timeout_ms
//  out_ch    out  valid/ready          out_handle, status, entry_count
//
//  One request per cycle sustained while out_ch is ready; a request is first
//  written into the two-entry queue, and its result is registered as the job leaves it.
//  The cell row settles a push or pop in a single register update.
//  Reset (rst_n low, synchronous) clears time, count and cell valid bits.
//  A stalled result stops the back end; the front keeps taking requests
//  until the job queue is full.
module deadline_priority_queue_unit (
  input  wire       clk,
  input  wire       rst_n,
  dpq_in_if.sink    in_ch,
  dpq_out_if.source out_ch
);
  import dpq_pkg::*;

  job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;

  dpq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  dpq_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_job(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_job(b_job), .rd_valid(b_valid), .rd_ready(b_ready)
  );

  dpq_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job(b_job), .job_valid(b_valid), .job_ready(b_ready),
    .out_ch(out_ch)
  );

endmodule
`default_nettype wire
